// ===== rtl/integer_square_root_defines.svh =====
// Assertion macros shared by the integer square root RTL.
// Included by the files that check pipeline invariants; depends on nothing.
`ifndef INTEGER_SQUARE_ROOT_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ISQRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isqrt check failed: same-cycle implication");

// Checks that the consequent holds in the cycle after the antecedent.
`define ISQRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isqrt check failed: next-cycle implication");

`endif

// ===== rtl/isqrt_pkg.sv =====
// Package for the integer square root block: width helper functions.
// Used by isqrt_stage and integer_square_root; depends on nothing.
`default_nettype none

package isqrt_pkg;

   localparam int MAX_VALUE_WIDTH = 64;

   // Number of root bits for a value of the given width.
   function automatic int root_width_of(input int value_width);
      return (value_width + 1) >> 1;
   endfunction

   // Width rounded up to whole bytes.
   function automatic int byte_pad(input int width);
      return ((width + 7) >> 3) << 3;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_square_root.sv =====
// Channel   Ports              Payload (lowest bit first)
// request   req_t{valid,ready} req_tdata: value
// response  rsp_t{valid,ready} rsp_tdata: root
//
// The pipeline has one stage per root bit, ROOT_WIDTH = (VALUE_WIDTH + 1) / 2
// stages (16 at the default width). A new item can enter in every cycle while
// the pipeline is not both full and stalled; each stage does one compare and subtract.
// Reset clears the stage valid bits; payload registers are not reset.
// A stalled response holds its stage; empty stages upstream still fill.
// Depends on isqrt_pkg, isqrt_stage and integer_square_root_defines.svh.
`default_nettype none
`include "integer_square_root_defines.svh"

module integer_square_root
   import isqrt_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // value
   input  wire logic [byte_pad(VALUE_WIDTH)-1:0]       req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // root
   output logic [byte_pad(root_width_of(VALUE_WIDTH))-1:0] rsp_tdata
);

   localparam int ROOT_WIDTH = root_width_of(VALUE_WIDTH);
   localparam int BITS_WIDTH = 2 * ROOT_WIDTH;
   localparam int OUT_WIDTH  = byte_pad(ROOT_WIDTH);

   logic                    stage_valid [0:ROOT_WIDTH];
   logic                    stage_ready [0:ROOT_WIDTH];
   logic [ROOT_WIDTH:0]     stage_rem   [0:ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0]   stage_root  [0:ROOT_WIDTH];
   logic [BITS_WIDTH-1:0]   stage_bits  [0:ROOT_WIDTH];

   assign stage_valid[0] = req_tvalid;
   assign req_tready     = stage_ready[0];
   assign stage_rem[0]   = '0;
   assign stage_root[0]  = '0;
   assign stage_bits[0]  = BITS_WIDTH'(req_tdata[VALUE_WIDTH-1:0]);

   for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_stage
      isqrt_stage #(
         .ROOT_WIDTH (ROOT_WIDTH)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_rem    (stage_rem[i]),
         .in_root   (stage_root[i]),
         .in_bits   (stage_bits[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_rem   (stage_rem[i+1]),
         .out_root  (stage_root[i+1]),
         .out_bits  (stage_bits[i+1])
      );
   end

   assign stage_ready[ROOT_WIDTH] = rsp_tready;
   assign rsp_tvalid = stage_valid[ROOT_WIDTH];
   assign rsp_tdata  = OUT_WIDTH'(stage_root[ROOT_WIDTH]);

   // Input back-pressure only arises once the whole pipeline is full and stalled.
   `ISQRT_ASSERT_SAME(a_full_stall, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)
   `ISQRT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

`default_nettype wire

// ===== rtl/isqrt_stage.sv =====
// One pipeline stage of the digit-by-digit square root: settles one root bit.
// Depends on isqrt_pkg and integer_square_root_defines.svh.
`default_nettype none
`include "integer_square_root_defines.svh"

module isqrt_stage
   import isqrt_pkg::*;
#(
   parameter int ROOT_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [ROOT_WIDTH:0]       in_rem,
   input  wire logic [ROOT_WIDTH-1:0]     in_root,
   input  wire logic [2*ROOT_WIDTH-1:0]   in_bits,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [ROOT_WIDTH:0]            out_rem,
   output logic [ROOT_WIDTH-1:0]          out_root,
   output logic [2*ROOT_WIDTH-1:0]        out_bits
);

   localparam int BITS_WIDTH = 2 * ROOT_WIDTH;
   localparam int WORK_WIDTH = ROOT_WIDTH + 3;

   logic                    valid_ff;
   logic [ROOT_WIDTH:0]     rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0]   root_ff, root_in;
   logic [BITS_WIDTH-1:0]   bits_ff, bits_in;
   logic [WORK_WIDTH-1:0]   shifted, trial, diff;
   logic                    fits;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shifted = {in_rem, in_bits[BITS_WIDTH-1 -: 2]};
      trial   = {1'b0, in_root, 2'b01};
      diff    = shifted - trial;
      fits    = shifted >= trial;
      rem_in  = fits ? diff[ROOT_WIDTH:0] : shifted[ROOT_WIDTH:0];
      root_in = {in_root[ROOT_WIDTH-2:0], fits};
      bits_in = {in_bits[BITS_WIDTH-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         bits_ff <= bits_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_bits  = bits_ff;

   // The partial remainder never exceeds twice the partial root.
   `ISQRT_ASSERT_SAME(a_rem_bound, clock, reset, valid_ff, rem_ff <= {root_ff, 1'b0})
   `ISQRT_ASSERT_NEXT(a_stall_hold, clock, reset, valid_ff && !out_ready,
                      valid_ff && $stable(root_ff) && $stable(rem_ff))

endmodule

`default_nettype wire

// ===== dv/integer_square_root_tb.sv =====
// Self-checking testbench for integer_square_root: drives values over the request stream
// and compares each root against a bitwise floor square root predictor.
// Depends on isqrt_pkg and the integer_square_root RTL.
module integer_square_root_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import isqrt_pkg::*;

   localparam int VALUE_WIDTH = 32;
   localparam int ROOT_WIDTH = root_width_of(VALUE_WIDTH);
   localparam int REQ_BITS = byte_pad(VALUE_WIDTH);
   localparam int RSP_BITS = byte_pad(ROOT_WIDTH);
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD = 300;

   typedef enum {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;

   logic [ROOT_WIDTH-1:0] expected_roots[$];
   logic [ROOT_WIDTH-1:0] oldest_root;
   ready_mode_type        ready_mode = READY_ALWAYS;
   int                    holdoff_asked = 0;
   int                    holdoff_served = 0;
   int                    holdoff_left = 0;
   int                    ready_phase = 0;
   int                    burst_left = 0;
   bit                    gaps_on = 1'b1;
   int                    values_accepted = 0;
   int                    roots_checked = 0;
   int                    held_cycles = 0;
   int                    idle_cycles = 0;
   int                    failures = 0;

   integer_square_root #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [ROOT_WIDTH-1:0] floor_root_of(input logic [VALUE_WIDTH-1:0] value);
      logic [ROOT_WIDTH-1:0] root;
      logic [ROOT_WIDTH-1:0] trial;
      logic [2*ROOT_WIDTH-1:0] square;
      root = '0;
      for (int b = ROOT_WIDTH - 1; b >= 0; b--) begin
         trial = root | (ROOT_WIDTH'(1) << b);
         square = trial * trial;
         if (square <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      logic [VALUE_WIDTH-1:0] value;
      logic [ROOT_WIDTH-1:0] root;
      root = $urandom_range(0, (1 << ROOT_WIDTH) - 1);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            value = $urandom();
         end
         3: begin
            value = $urandom_range(0, 1023);
         end
         4, 5: begin
            value = $urandom() >> $urandom_range(0, VALUE_WIDTH - 1);
         end
         6: begin
            value = root * root;
         end
         7: begin
            value = root * root - 1;
         end
         8: begin
            value = root * root + 1;
         end
         default: begin
            value = (root + 1) * (root + 1) - 1;
         end
      endcase
      return value;
   endfunction

   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_roots.size() != 0) begin
         @(posedge clock);
      end
      repeat (ROOT_WIDTH + 8) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [VALUE_WIDTH-1:0] corner_values[$];
      corner_values = {32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd15, 32'd16, 32'd17,
                       32'd99, 32'd100, 32'd101, 32'h3FFF_FFFF, 32'h4000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFD_FFFF, 32'hFFFE_0000,
                       32'hFFFE_0001, 32'hFFFE_0002, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
      ready_mode <= READY_RANDOM;
      foreach (corner_values[i]) begin
         send_value(corner_values[i]);
      end
      drain_results();
   endtask

   task automatic test_random_values();
      gaps_on = 1'b1;
      ready_mode <= READY_RANDOM;
      repeat (500) send_value(random_value());
      drain_results();
   endtask

   task automatic test_streaming();
      gaps_on = 1'b0;
      ready_mode <= READY_ALWAYS;
      repeat (200) send_value(random_value());
      drain_results();
      gaps_on = 1'b1;
   endtask

   task automatic test_periodic_stall();
      gaps_on = 1'b1;
      ready_mode <= READY_PERIODIC;
      repeat (250) send_value(random_value());
      drain_results();
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      ready_mode <= READY_ALWAYS;
      holdoff_asked <= holdoff_asked + 1;
      repeat (90) send_value(random_value());
      gaps_on = 1'b1;
      ready_mode <= READY_RANDOM;
      holdoff_asked <= holdoff_asked + 1;
      repeat (90) send_value(random_value());
      drain_results();
   endtask

   // The receiver either follows its ready pattern or serves a requested long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_tready <= 1'b0;
         holdoff_left <= holdoff_left - 1;
         held_cycles <= held_cycles + 1;
      end else if (holdoff_served != holdoff_asked) begin
         rsp_tready <= 1'b0;
         holdoff_served <= holdoff_served + 1;
         holdoff_left <= LONG_HOLD;
      end else begin
         ready_phase <= (ready_phase + 1) % 13;
         case (ready_mode)
            READY_ALWAYS: begin
               rsp_tready <= 1'b1;
            end
            READY_RANDOM: begin
               rsp_tready <= ($urandom_range(0, 9) < 6);
            end
            default: begin
               rsp_tready <= (ready_phase < 8);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_roots.size() == 0) begin
               $error("root arrived with no value pending: actual %0d", rsp_tdata);
               failures++;
            end else begin
               oldest_root = expected_roots.pop_front();
               if (rsp_tdata !== RSP_BITS'(oldest_root)) begin
                  $error("root mismatch: expected %0d, actual %0d", oldest_root, rsp_tdata);
                  failures++;
               end
               roots_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_roots.push_back(floor_root_of(req_tdata[VALUE_WIDTH-1:0]));
            values_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_values();
      test_streaming();
      test_periodic_stall();
      test_backpressure();
      if (expected_roots.size() != 0) begin
         $error("%0d roots never arrived", expected_roots.size());
         failures++;
      end
      $display("summary: %0d values transferred and %0d roots checked, with bursty,",
               values_accepted, roots_checked);
      $display("summary: back-to-back and stalled traffic and %0d hold-off cycles; %0d errors",
               held_cycles, failures);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
